FILE: hw/rtl/sdp_pkg.sv
// Shared types, widths and command codes for the slot duration profiler.
`default_nettype none
package sdp_pkg;

   localparam int TIME_BITS     = 48;
   localparam int SLOTS_DEFAULT = 64;

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_END   = 2'd1;
   localparam logic [1:0] CMD_ROLL  = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   // one profiling slot, stored as a single memory word
   typedef struct packed {
      logic [TIME_BITS-1:0] start_time;
      logic [55:0]          open_accum;
      logic [31:0]          open_calls;
      logic [TIME_BITS-1:0] gap_min;
      logic [TIME_BITS-1:0] gap_max;
      logic                 seen;
      logic [31:0]          closed_calls;
      logic [55:0]          closed_elapsed;
      logic [39:0]          total_calls;
      logic [63:0]          total_ticks;
      logic [55:0]          hist_min;
      logic [55:0]          hist_max;
      logic [55:0]          hist_avg;
      logic                 hist_valid;
   } sdp_entry_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic rd_en;
      logic exec_wr;
      logic load_rsp;
      logic roll_calc;
      logic roll_wr;
      logic walk_next;
   } sdp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] command;
      logic       rsp_free;
      logic       div_needed;
      logic       div_idle;
      logic       walk_last;
   } sdp_stat_type;

endpackage
`default_nettype wire

FILE: hw/rtl/sdp_divider.sv
// Restoring divider, 64-bit dividend by 40-bit divisor, one quotient bit a cycle.
`default_nettype none
module sdp_divider
   import sdp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [39:0] divisor,
   output logic             idle,
   output logic [55:0]      quotient_sat
);

   logic [63:0] quo_ff, quo_in;
   logic [39:0] rem_ff, rem_in;
   logic [39:0] dsr_ff, dsr_in;
   logic [6:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic [40:0] rem_sh;
   logic        ge;

   // shift in one dividend bit and try the subtract
   always_comb begin
      rem_sh   = {rem_ff, quo_ff[63]};
      ge       = rem_sh >= {1'b0, dsr_ff};
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      if (start) begin
         quo_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
         count_in = 7'd64;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = ge ? 40'(rem_sh - {1'b0, dsr_ff}) : rem_sh[39:0];
         quo_in   = {quo_ff[62:0], ge};
         count_in = 7'(count_ff - 7'd1);
         busy_in  = (count_ff != 7'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign idle         = !busy_ff;
   assign quotient_sat = (quo_ff[63:56] != 8'd0) ? {56{1'b1}} : quo_ff[55:0];

endmodule
`default_nettype wire

FILE: hw/rtl/sdp_datapath.sv
// Slot table memory, update arithmetic, rollover walk and response register.
`default_nettype none
module sdp_datapath
   import sdp_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
)(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire sdp_cmd_type  cmd,
   output sdp_stat_type      stat,
   input  wire logic [1:0]   req_command,
   input  wire logic [5:0]   req_slot,
   input  wire logic [47:0]  req_timestamp,
   input  wire logic         req_clear_history,
   input  wire logic [55:0]  req_threshold_ticks,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [31:0]       rsp_last_call_count,
   output logic [55:0]       rsp_last_elapsed,
   output logic [55:0]       rsp_history_min,
   output logic [55:0]       rsp_history_max,
   output logic [55:0]       rsp_history_avg,
   output logic [47:0]       rsp_gap_min,
   output logic [47:0]       rsp_gap_max,
   output logic [55:0]       rsp_open_sum,
   output logic              rsp_seen,
   output logic              rsp_over_threshold
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   // request registers
   logic [1:0]     cmd_ff;
   logic [5:0]     slot_ff;
   logic [47:0]    now_ff;
   logic           clear_ff;
   logic [55:0]    thr_ff;

   logic [IDX_W-1:0] walk_ff, walk_in;
   logic [SLOTS-1:0] valid_ff, valid_in;
   sdp_entry_type    mem [SLOTS];
   sdp_entry_type    rdata_ff;
   logic             rvalid_ff;
   sdp_entry_type    cur;

   logic [7:0]       slot_ext;
   logic             slot_ok;
   logic [IDX_W-1:0] addr;

   sdp_entry_type    start_e, end_e, roll_e, roll_ff, wdata;
   logic             wr_en;
   logic [47:0]      gap;
   logic [56:0]      acc_sum;
   logic [40:0]      tc_sum;
   logic [64:0]      tt_sum;
   logic [39:0]      tc_new;
   logic [63:0]      tt_new;
   logic             div_needed;
   logic             div_used_ff;
   logic             div_idle;
   logic [55:0]      quo_sat;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_free;

   // hold the accepted item
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff   <= req_command;
         slot_ff  <= req_slot;
         now_ff   <= req_timestamp;
         clear_ff <= req_clear_history;
         thr_ff   <= req_threshold_ticks;
      end
   end

   assign slot_ext = {2'b00, slot_ff};
   assign slot_ok  = (32'(slot_ext) < SLOTS);
   assign addr     = (cmd_ff == CMD_ROLL) ? walk_ff : slot_ext[IDX_W-1:0];

   // read the slot; a never-written slot reads as zero
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rdata_ff  <= mem[addr];
         rvalid_ff <= valid_ff[addr];
      end
      if (wr_en) begin
         mem[addr] <= wdata;
      end
   end
   assign cur = rvalid_ff ? rdata_ff : '0;

   // start: latch the timestamp
   always_comb begin
      start_e            = cur;
      start_e.start_time = now_ff;
   end

   // end: accumulate the gap, count the call, track gap extremes
   always_comb begin
      gap     = 48'(now_ff - cur.start_time);
      acc_sum = {1'b0, cur.open_accum} + {9'd0, gap};
      end_e   = cur;
      end_e.open_calls = (cur.open_calls == '1) ? cur.open_calls
                                                : 32'(cur.open_calls + 32'd1);
      end_e.open_accum = acc_sum[56] ? {56{1'b1}} : acc_sum[55:0];
      if (!cur.seen) begin
         end_e.gap_min = gap;
         end_e.gap_max = gap;
      end else begin
         if (gap < cur.gap_min) end_e.gap_min = gap;
         if (gap > cur.gap_max) end_e.gap_max = gap;
      end
      end_e.seen = 1'b1;
   end

   // rollover: close the interval, add to totals, fold or clear history
   always_comb begin
      tc_sum = {1'b0, cur.total_calls} + {9'd0, cur.open_calls};
      tt_sum = {1'b0, cur.total_ticks} + {9'd0, cur.open_accum};
      tc_new = tc_sum[40] ? {40{1'b1}} : tc_sum[39:0];
      tt_new = tt_sum[64] ? {64{1'b1}} : tt_sum[63:0];
      div_needed = !clear_ff && (cur.open_calls != 32'd0) && (tc_new != 40'd0);
      roll_e = cur;
      roll_e.closed_calls   = cur.open_calls;
      roll_e.closed_elapsed = cur.open_accum;
      roll_e.total_calls    = tc_new;
      roll_e.total_ticks    = tt_new;
      roll_e.hist_avg       = '0;
      if (clear_ff) begin
         roll_e.hist_min   = '0;
         roll_e.hist_max   = '0;
         roll_e.hist_valid = 1'b0;
         roll_e.seen       = 1'b0;
      end else if (!cur.hist_valid) begin
         roll_e.hist_min   = cur.open_accum;
         roll_e.hist_max   = cur.open_accum;
         roll_e.hist_valid = 1'b1;
      end else begin
         if (cur.open_accum < cur.hist_min) roll_e.hist_min = cur.open_accum;
         if (cur.open_accum > cur.hist_max) roll_e.hist_max = cur.open_accum;
      end
      roll_e.open_calls = '0;
      roll_e.start_time = '0;
      roll_e.open_accum = '0;
      roll_e.gap_min    = '1;
      roll_e.gap_max    = '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.roll_calc) begin
         roll_ff     <= roll_e;
         div_used_ff <= div_needed;
      end
   end

   sdp_divider u_div (
      .clock        (clock),
      .reset        (reset),
      .start        (cmd.roll_calc && div_needed),
      .dividend     (tt_new),
      .divisor      (tc_new),
      .idle         (div_idle),
      .quotient_sat (quo_sat)
   );

   // select the write word
   always_comb begin
      wr_en = cmd.roll_wr || (cmd.exec_wr && slot_ok);
      if (cmd.roll_wr) begin
         wdata = roll_ff;
         if (div_used_ff) wdata.hist_avg = quo_sat;
      end else if (cmd_ff == CMD_START) begin
         wdata = start_e;
      end else begin
         wdata = end_e;
      end
   end

   // walk counter and per-slot valid bits
   always_comb begin
      walk_in  = walk_ff;
      valid_in = valid_ff;
      if (cmd.accept) walk_in = '0;
      else if (cmd.walk_next) walk_in = IDX_W'(walk_ff + 1'b1);
      if (wr_en) valid_in[addr] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         walk_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         walk_ff  <= walk_in;
      end
   end

   // response register
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load_rsp) begin
         if (slot_ok) begin
            rsp_last_call_count <= cur.closed_calls;
            rsp_last_elapsed    <= cur.closed_elapsed;
            rsp_history_min     <= cur.hist_min;
            rsp_history_max     <= cur.hist_max;
            rsp_history_avg     <= cur.hist_avg;
            rsp_gap_min         <= cur.gap_min;
            rsp_gap_max         <= cur.gap_max;
            rsp_open_sum        <= cur.open_accum;
            rsp_seen            <= cur.seen;
            rsp_over_threshold  <= (cur.open_accum >= thr_ff);
         end else begin
            rsp_last_call_count <= '0;
            rsp_last_elapsed    <= '0;
            rsp_history_min     <= '0;
            rsp_history_max     <= '0;
            rsp_history_avg     <= '0;
            rsp_gap_min         <= '0;
            rsp_gap_max         <= '0;
            rsp_open_sum        <= '0;
            rsp_seen            <= 1'b0;
            rsp_over_threshold  <= 1'b0;
         end
      end
   end
   assign rsp_valid = rsp_valid_ff;

   // report status to the controller
   always_comb begin
      stat.command    = cmd_ff;
      stat.rsp_free   = rsp_free;
      stat.div_needed = div_needed;
      stat.div_idle   = div_idle;
      stat.walk_last  = (walk_ff == LAST_IDX);
   end

endmodule
`default_nettype wire

FILE: hw/rtl/sdp_ctrl.sv
// Controller state machine that sequences item reads, writes and the rollover walk.
`default_nettype none
module sdp_ctrl
   import sdp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire sdp_stat_type stat,
   output sdp_cmd_type       cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_WB   = 3'd4;

   logic [2:0] state_ff, state_in;

   // advance through read, execute and, on rollover, divide if needed and write back
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_RD;
            end
         end
         S_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_EXEC;
         end
         S_EXEC: begin
            case (stat.command)
               CMD_START, CMD_END: begin
                  cmd.exec_wr = 1'b1;
                  state_in    = S_IDLE;
               end
               CMD_READ: begin
                  if (stat.rsp_free) begin
                     cmd.load_rsp = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
               default: begin
                  cmd.roll_calc = 1'b1;
                  state_in      = stat.div_needed ? S_DIV : S_WB;
               end
            endcase
         end
         S_DIV: begin
            if (stat.div_idle) state_in = S_WB;
         end
         S_WB: begin
            cmd.roll_wr = 1'b1;
            if (stat.walk_last) begin
               state_in = S_IDLE;
            end else begin
               cmd.walk_next = 1'b1;
               state_in      = S_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule
`default_nettype wire

FILE: hw/rtl/slot_duration_profiler.sv
// Slot duration profiler: top level joining the controller and the datapath.
// Start and end read the slot and write it back before the next item is taken.
// Read waits until the output register is free, then loads its result there.
// Rollover visits every slot, waiting for the 64-step divider when the average
// needs it; read, update and write-back of the slot memory set the pace.
// Synchronous reset marks every slot empty at once; empty slots read as zero.
`default_nettype none
module slot_duration_profiler
   import sdp_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [5:0]  req_slot,
   input  wire logic [47:0] req_timestamp,
   input  wire logic        req_clear_history,
   input  wire logic [55:0] req_threshold_ticks,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_last_call_count,
   output logic [55:0]      rsp_last_elapsed,
   output logic [55:0]      rsp_history_min,
   output logic [55:0]      rsp_history_max,
   output logic [55:0]      rsp_history_avg,
   output logic [47:0]      rsp_gap_min,
   output logic [47:0]      rsp_gap_max,
   output logic [55:0]      rsp_open_sum,
   output logic             rsp_seen,
   output logic             rsp_over_threshold
);

   sdp_cmd_type  cmd;
   sdp_stat_type stat;

   sdp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sdp_datapath #(.SLOTS(SLOTS)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_command         (req_command),
      .req_slot            (req_slot),
      .req_timestamp       (req_timestamp),
      .req_clear_history   (req_clear_history),
      .req_threshold_ticks (req_threshold_ticks),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_last_call_count (rsp_last_call_count),
      .rsp_last_elapsed    (rsp_last_elapsed),
      .rsp_history_min     (rsp_history_min),
      .rsp_history_max     (rsp_history_max),
      .rsp_history_avg     (rsp_history_avg),
      .rsp_gap_min         (rsp_gap_min),
      .rsp_gap_max         (rsp_gap_max),
      .rsp_open_sum        (rsp_open_sum),
      .rsp_seen            (rsp_seen),
      .rsp_over_threshold  (rsp_over_threshold)
   );

endmodule
`default_nettype wire
